// ----- rtl/sha256_byte_stream_hasher_unit_assert.svh -----
// Assertion macros used by the checker file.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_ASSERT_SVH

// Check that an implication holds at every clock edge outside reset.
`define SHA_ASSERT_IMP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SHA_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ----- rtl/sha_pkg.sv -----
package sha_pkg;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROUND,
      ST_FOLD,
      ST_PAD,
      ST_EMIT
   } state_type;

   // Command group from the controller to the datapath.
   typedef struct packed {
      logic       absorb;      // write the input byte into the block buffer
      logic       round_start; // load the working words from the chain
      logic       round_step;  // perform one compression round
      logic       fold;        // add working words into the chain
      logic       pad_write;   // write one padding byte
      logic       reinit;      // restore the initial state
      logic       emit_shift;  // advance the digest word pointer
   } cmd_type;

   // Status group from the datapath to the controller.
   typedef struct packed {
      logic       round_last;  // round counter at 63
      logic       pad_full;    // padding reached the end of a block
      logic       pad_length;  // the block being padded holds the length
      logic       emit_last;   // pointer at the final digest word
   } status_type;

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [7:0] PAD_MARK = 8'h80;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

// ----- rtl/sha_ctrl.sv -----
module sha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_byte_valid,
   input  logic                req_end_of_message,
   input  logic                fill_last,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output sha_pkg::cmd_type    cmd,
   input  sha_pkg::status_type status
);
   import sha_pkg::*;

   state_type state_ff, state_in;
   logic      close_ff, close_in;
   logic      accept;

   assign accept = req_valid && !req_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      close_in = close_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               close_in = req_end_of_message;
               if (req_byte_valid && fill_last) begin
                  state_in = ST_ROUND;
               end else if (req_end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            if (status.round_last) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!close_ff) begin
               state_in = ST_IDLE;
            end else if (status.pad_length) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (status.pad_full) begin
               state_in = ST_ROUND;
            end
         end
         ST_EMIT: begin
            if (!rsp_stall && status.emit_last) begin
               state_in = ST_IDLE;
               close_in = 1'b0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall        = 1'b0;
            cmd.absorb       = accept && req_byte_valid;
            cmd.round_start  = accept && req_byte_valid && fill_last;
         end
         ST_ROUND: begin
            cmd.round_step = 1'b1;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         ST_PAD: begin
            cmd.pad_write   = 1'b1;
            cmd.round_start = status.pad_full;
         end
         ST_EMIT: begin
            rsp_valid      = 1'b1;
            cmd.emit_shift = !rsp_stall;
            cmd.reinit     = !rsp_stall && status.emit_last;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         close_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         close_ff <= close_in;
      end
   end

endmodule

// ----- rtl/sha_dpath.sv -----
module sha_dpath (
   input  logic                clock,
   input  logic                reset,
   input  logic [7:0]          req_data_byte,
   input  sha_pkg::cmd_type    cmd,
   output sha_pkg::status_type status,
   output logic                fill_last,
   output logic [31:0]         rsp_digest_word,
   output logic [2:0]          rsp_word_index,
   output logic                rsp_last_word
);
   import sha_pkg::*;

   // Block buffer as sixteen big-endian words, one byte lane written per cycle.
   logic [31:0] block_mem [16];
   logic [5:0]  fill_ff, fill_in;
   logic [63:0] bits_ff, bits_in;
   logic [31:0] chain_ff [8];
   logic [31:0] work_ff [8];
   logic [31:0] sched_ff [16];
   logic [5:0]  round_ff;
   logic        len_block_ff;
   logic        pad_mark_done_ff;
   logic [2:0]  emit_ff;
   logic [7:0]  pad_byte;
   logic [31:0] w_cur, w_new, s0, s1, t1, t2, e, a;
   logic [31:0] big_s0, big_s1, ch, maj;

   assign fill_last = (fill_ff == 6'd63);

   // Padding byte: mark, zeros, then the bit count in the last eight bytes of the length block.
   always_comb begin
      pad_byte = 8'h00;
      if (!pad_mark_done_ff) begin
         pad_byte = PAD_MARK;
      end else if (len_block_ff && fill_ff >= 6'd56) begin
         pad_byte = bits_ff[8 * (7 - fill_ff[2:0]) +: 8];
      end
   end

   assign status.pad_full   = cmd.pad_write && (fill_ff == 6'd63);
   assign status.round_last = (round_ff == 6'd63);
   assign status.pad_length = len_block_ff;
   assign status.emit_last  = (emit_ff == 3'd7);

   // Byte write into the buffer.
   always_ff @(posedge clock) begin
      if (cmd.absorb) begin
         block_mem[fill_ff[5:2]][8 * (3 - fill_ff[1:0]) +: 8] <= req_data_byte;
      end else if (cmd.pad_write) begin
         block_mem[fill_ff[5:2]][8 * (3 - fill_ff[1:0]) +: 8] <= pad_byte;
      end
   end

   // Fill pointer and bit count.
   always_comb begin
      fill_in = fill_ff;
      bits_in = bits_ff;
      if (cmd.absorb) begin
         fill_in = fill_ff + 6'd1;
         bits_in = bits_ff + 64'd8;
      end else if (cmd.pad_write) begin
         fill_in = fill_ff + 6'd1;
      end
   end

   // Message schedule: sixteen word window, one new word per round.
   assign w_cur  = (round_ff < 6'd16) ? block_mem[round_ff[3:0]] : w_new;
   assign s0     = rotr(sched_ff[1], 7) ^ rotr(sched_ff[1], 18) ^ (sched_ff[1] >> 3);
   assign s1     = rotr(sched_ff[14], 17) ^ rotr(sched_ff[14], 19) ^ (sched_ff[14] >> 10);
   assign w_new  = sched_ff[0] + s0 + sched_ff[9] + s1;

   // One compression round.
   assign e      = work_ff[4];
   assign a      = work_ff[0];
   assign big_s1 = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
   assign big_s0 = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
   assign ch     = (e & work_ff[5]) ^ (~e & work_ff[6]);
   assign maj    = (a & work_ff[1]) ^ (a & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
   assign t1     = work_ff[7] + big_s1 + ch + ROUND_K[round_ff] + w_cur;
   assign t2     = big_s0 + maj;

   always_ff @(posedge clock) begin
      if (cmd.round_start) begin
         work_ff <= chain_ff;
      end else if (cmd.round_step) begin
         work_ff[7] <= work_ff[6];
         work_ff[6] <= work_ff[5];
         work_ff[5] <= work_ff[4];
         work_ff[4] <= work_ff[3] + t1;
         work_ff[3] <= work_ff[2];
         work_ff[2] <= work_ff[1];
         work_ff[1] <= work_ff[0];
         work_ff[0] <= t1 + t2;
      end
      if (cmd.round_step) begin
         for (int i = 0; i < 15; i++) begin
            sched_ff[i] <= sched_ff[i + 1];
         end
         sched_ff[15] <= w_cur;
      end
   end

   // Control registers: chain, counters, padding flags.
   always_ff @(posedge clock) begin
      if (reset || cmd.reinit) begin
         chain_ff         <= INIT_H;
         fill_ff          <= '0;
         bits_ff          <= '0;
         round_ff         <= '0;
         len_block_ff     <= 1'b0;
         pad_mark_done_ff <= 1'b0;
         emit_ff          <= '0;
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         if (cmd.round_start) begin
            round_ff <= '0;
         end else if (cmd.round_step) begin
            round_ff <= round_ff + 6'd1;
         end
         if (cmd.fold) begin
            for (int i = 0; i < 8; i++) begin
               chain_ff[i] <= chain_ff[i] + work_ff[i];
            end
            // A padded block without room for the length is followed by one.
            if (pad_mark_done_ff) begin
               len_block_ff <= 1'b1;
            end
         end
         if (cmd.pad_write) begin
            pad_mark_done_ff <= 1'b1;
            // Length fits in this block if the mark lands at 55 or earlier.
            if (!pad_mark_done_ff && fill_ff <= 6'd55) begin
               len_block_ff <= 1'b1;
            end
         end
         if (cmd.emit_shift) begin
            emit_ff <= emit_ff + 3'd1;
         end
      end
   end

   assign rsp_digest_word = chain_ff[emit_ff];
   assign rsp_word_index  = emit_ff;
   assign rsp_last_word   = (emit_ff == 3'd7);

endmodule

// ----- rtl/sha256_byte_stream_hasher_unit.sv -----
// SHA-256 over a byte stream.
// Input channel req_: one item per beat carries req_data_byte with
// req_byte_valid, and req_end_of_message closes the message after the byte.
// Result channel rsp_: eight beats per closed message, digest words H0..H7
// on rsp_digest_word with rsp_word_index and rsp_last_word on the eighth.
// A byte that does not complete a block is written into the buffer and leaves
// the block ready for the next byte. The 64th byte of a block starts the
// compression: 64 rounds of the single round unit, then a fold into the chain.
// At the end of a message the padding writes one byte a cycle into the
// block buffer up to the end of the block, then the block is compressed;
// a tail of 56 or more bytes needs a second padded block.
// The digest words then wait on the output; req_stall stays high until the
// last word is taken, and rsp_stall holds the current word in place.
// Reset (synchronous) restores the initial hash values and clears the
// fill pointer and bit count; the block accepts items on the next cycle.
module sha256_byte_stream_hasher_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   import sha_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       fill_last;

   sha_ctrl u_ctrl (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_byte_valid     (req_byte_valid),
      .req_end_of_message (req_end_of_message),
      .fill_last          (fill_last),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .cmd                (cmd),
      .status             (status)
   );

   sha_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .cmd             (cmd),
      .status          (status),
      .fill_last       (fill_last),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

endmodule

// ----- rtl/sha_checker.sv -----
`include "sha256_byte_stream_hasher_unit_assert.svh"

module sha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // The digest is shown only while input is held off.
   `SHA_ASSERT_NEVER(a_no_overlap, clock, reset, rsp_valid && !req_stall, "rsp while req open")
   // A taken word that is not the last is followed by the next index.
   `SHA_ASSERT_IMP(a_index_step, clock, reset, (rsp_valid && !rsp_stall && !rsp_last_word) |=> (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1), "word index skipped")
   // The last word flag marks index seven only.
   `SHA_ASSERT_IMP(a_last_index, clock, reset, rsp_valid |-> (rsp_last_word == (rsp_word_index == 3'd7)), "last word flag wrong")
   // A stalled word holds its value.
   `SHA_ASSERT_IMP(a_hold, clock, reset, (rsp_valid && rsp_stall) |=> $stable(rsp_digest_word), "stalled word changed")

endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (.*);
